[hdl/tlfp_pkg.sv]
// Shared types, codes and constants for the lidar frame parser.
// No dependencies; imported by every module of the block.
package tlfp_pkg;

    // Frame format
    localparam logic [7:0] SYNC_BYTE   = 8'h59;
    localparam int         PAYLOAD_LEN = 6;
    localparam int         POS_W       = $clog2(PAYLOAD_LEN);
    localparam logic [7:0] SUM_SEED    = 8'(2 * 8'h59);

    // Device adjustment constants
    localparam logic [7:0]  INTEG_SHORT = 8'd7;
    localparam logic [7:0]  REL_MIN     = 8'd7;
    localparam logic [7:0]  CONF_MIN    = 8'd90;
    localparam logic [15:0] SHORT_CORR  = 16'd13;

    // Timer defaults (ticks)
    localparam int TIMEOUT_TICKS_DEF    = 200;
    localparam int RECONF_GAP_TICKS_DEF = 500;

    // Event queue depth
    localparam int QUEUE_DEPTH = 2;

    // Input operations
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Register indexes
    localparam logic [1:0] REG_DEVICE_TYPE = 2'd0;
    localparam logic [1:0] REG_RANGE_MIN   = 2'd1;
    localparam logic [1:0] REG_RANGE_MAX   = 2'd2;

    // Device types
    localparam logic [1:0] DEV_SHORT   = 2'd0;
    localparam logic [1:0] DEV_LONG    = 2'd1;
    localparam logic [1:0] DEV_CONF    = 2'd2;
    localparam logic [1:0] DEV_UNKNOWN = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_VALID  = 3'd0;
    localparam logic [2:0] ST_RANGE  = 3'd1;
    localparam logic [2:0] ST_SUM    = 3'd2;
    localparam logic [2:0] ST_HWFAIL = 3'd3;
    localparam logic [2:0] ST_RECONF = 3'd4;

    // Front-end frame phase, one-hot
    typedef enum logic [3:0] {
        PH_SYNC1 = 4'b0001,
        PH_SYNC2 = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_SUM   = 4'b1000
    } phase_t;

    // Event kinds passed from front to back
    typedef enum logic [1:0] {
        EV_GOOD   = 2'd0,
        EV_BAD    = 2'd1,
        EV_RECONF = 2'd2
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [15:0] distance;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
    } event_t;

    typedef struct packed {
        logic [1:0]  dev_type;
        logic [15:0] range_min;
        logic [15:0] range_max;
    } cfg_t;

endpackage

[hdl/tof_lidar_frame_parser.sv]
// Top level of the lidar serial frame parser: register file and channel wiring.
// Depends on tlfp_pkg, tlfp_front, tlfp_queue and tlfp_back.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | tdata: rx_byte; tuser: operation
//  m_      | out | m_tvalid/m_tready | tdata: distance, checksum_errors; tuser: status
//  cfg_    | in  | cfg_valid/ready   | cfg_index, cfg_data
//
// One word per cycle is taken while the queue has room; each result passes through
// the event queue and then the output register. The parser step is combinational, and
// the result stage handles one word per clock while the m_ side is not stalled.
// Reset is synchronous and active low; it resets control and counters, not data.
// A stalled m_ side fills the two-entry event queue, then s_tready drops.
module tof_lidar_frame_parser
    import tlfp_pkg::*;
#(
    parameter int TIMEOUT_TICKS    = TIMEOUT_TICKS_DEF,
    parameter int RECONF_GAP_TICKS = RECONF_GAP_TICKS_DEF,
    parameter int Q_DEPTH          = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] distance, [31:16] checksum_errors
    output logic [2:0]  m_tuser,   // [2:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t   cfg_reg;
    logic   in_fire;
    logic   ev_push, ev_pop, q_empty, q_full;
    event_t ev_in, ev_head;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign in_fire   = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dev_type  <= DEV_SHORT;
            cfg_reg.range_min <= 16'd40;
            cfg_reg.range_max <= 16'd1200;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DEVICE_TYPE: cfg_reg.dev_type  <= cfg_data[1:0];
                REG_RANGE_MIN:   cfg_reg.range_min <= cfg_data;
                REG_RANGE_MAX:   cfg_reg.range_max <= cfg_data;
                default:         cfg_reg           <= cfg_reg;
            endcase
        end
    end

    tlfp_front #(
        .TIMEOUT_TICKS    (TIMEOUT_TICKS),
        .RECONF_GAP_TICKS (RECONF_GAP_TICKS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_op    (s_tuser),
        .in_byte  (s_tdata),
        .dev_type (cfg_reg.dev_type),
        .ev_push  (ev_push),
        .ev_data  (ev_in)
    );

    tlfp_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (ev_push),
        .push_data (ev_in),
        .pop       (ev_pop),
        .head      (ev_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    tlfp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .ev         (ev_head),
        .ev_avail   (!q_empty),
        .ev_pop     (ev_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_dist   (m_tdata[15:0]),
        .out_errs   (m_tdata[31:16])
    );

endmodule

[hdl/tlfp_front.sv]
// Front end: sync search, payload capture, running sum and tick timers.
// Depends on tlfp_pkg; pushes frame and reconfigure events into tlfp_queue.
module tlfp_front
    import tlfp_pkg::*;
#(
    parameter int TIMEOUT_TICKS    = TIMEOUT_TICKS_DEF,
    parameter int RECONF_GAP_TICKS = RECONF_GAP_TICKS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic       in_op,
    input  logic [7:0] in_byte,
    input  logic [1:0] dev_type,
    output logic       ev_push,
    output event_t     ev_data
);

    phase_t          phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]      sum_reg, sum_next;
    logic [7:0]      store_reg [PAYLOAD_LEN];
    logic [15:0]     sgf_reg, sgf_next;
    logic [15:0]     src_reg, src_next;
    logic [15:0]     sgf_inc, src_inc;
    logic            sum_ok;

    assign sgf_inc = (sgf_reg == 16'hFFFF) ? sgf_reg : sgf_reg + 16'd1;
    assign src_inc = (src_reg == 16'hFFFF) ? src_reg : src_reg + 16'd1;
    assign sum_ok  = (in_byte == sum_reg);

    // Parser and timer next state
    always_comb begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        sum_next         = sum_reg;
        sgf_next         = sgf_reg;
        src_next         = src_reg;
        ev_push          = 1'b0;
        ev_data.kind     = EV_GOOD;
        ev_data.distance = {store_reg[1], store_reg[0]};
        ev_data.byte4    = store_reg[4];
        ev_data.byte5    = store_reg[5];
        if (in_fire) begin
            if (in_op == OP_TICK) begin
                sgf_next = sgf_inc;
                src_next = src_inc;
                if ((sgf_inc > 16'(TIMEOUT_TICKS)) && (src_inc > 16'(RECONF_GAP_TICKS))) begin
                    src_next     = '0;
                    // only types that take a reconfigure command see it
                    ev_push      = (dev_type == DEV_SHORT) || (dev_type == DEV_LONG);
                    ev_data.kind = EV_RECONF;
                end
            end else begin
                case (phase_reg)
                    PH_SYNC1: begin
                        if (in_byte == SYNC_BYTE) phase_next = PH_SYNC2;
                    end
                    PH_SYNC2: begin
                        phase_next = (in_byte == SYNC_BYTE) ? PH_DATA : PH_SYNC1;
                        sum_next   = SUM_SEED;
                        pos_next   = '0;
                    end
                    PH_DATA: begin
                        sum_next = sum_reg + in_byte;
                        pos_next = pos_reg + POS_W'(1);
                        if (pos_reg == POS_W'(PAYLOAD_LEN - 1)) phase_next = PH_SUM;
                    end
                    PH_SUM: begin
                        phase_next   = PH_SYNC1;
                        pos_next     = '0;
                        ev_push      = 1'b1;
                        ev_data.kind = sum_ok ? EV_GOOD : EV_BAD;
                        if (sum_ok) sgf_next = '0;
                    end
                    default: begin
                        phase_next = PH_SYNC1;
                    end
                endcase
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC1;
            pos_reg   <= '0;
            sgf_reg   <= '0;
            src_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sgf_reg   <= sgf_next;
            src_reg   <= src_next;
        end
    end

    // Payload bytes and running sum
    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        if (in_fire && (in_op == OP_BYTE) && (phase_reg == PH_DATA)) begin
            store_reg[pos_reg] <= in_byte;
        end
    end

endmodule

[hdl/tlfp_queue.sv]
// Short event queue between the front end and the result stage.
// Depends on tlfp_pkg for the event word type.
module tlfp_queue
    import tlfp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  event_t push_data,
    input  logic   pop,
    output event_t head,
    output logic   empty,
    output logic   full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    event_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CW'(DEPTH));
    assign head  = mem_reg[rd_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            if (pop)  rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + CW'(1);
                2'b01:   cnt_reg <= cnt_reg - CW'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("event queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("event queue underflow");

endmodule

[hdl/tlfp_back.sv]
// Result stage: range check, device adjustment, error count, output register.
// Depends on tlfp_pkg; drains events from tlfp_queue.
module tlfp_back
    import tlfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  event_t      ev,
    input  logic        ev_avail,
    output logic        ev_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_status,
    output logic [15:0] out_dist,
    output logic [15:0] out_errs
);

    logic        valid_reg;
    logic [2:0]  status_reg, status_next;
    logic [15:0] dist_reg, dist_next;
    logic [15:0] errs_reg, errs_next;
    logic        in_range;

    assign ev_pop   = ev_avail && (!valid_reg || out_ready);
    assign in_range = (ev.distance >= cfg.range_min) && (ev.distance <= cfg.range_max);

    // Decide the result word for the queue head
    always_comb begin
        status_next = ST_VALID;
        dist_next   = '0;
        errs_next   = errs_reg;
        case (ev.kind)
            EV_RECONF: status_next = ST_RECONF;
            EV_BAD: begin
                status_next = ST_SUM;
                errs_next   = errs_reg + 16'd1;
            end
            EV_GOOD: begin
                if (!in_range) begin
                    status_next = ST_RANGE;
                end else begin
                    case (cfg.dev_type)
                        DEV_SHORT: begin
                            dist_next = (ev.byte4 == INTEG_SHORT) ? ev.distance - SHORT_CORR
                                                                  : ev.distance;
                        end
                        DEV_LONG: begin
                            if (ev.byte4 < REL_MIN) status_next = ST_RANGE;
                            else                    dist_next   = ev.distance;
                        end
                        DEV_CONF: begin
                            if (ev.byte5 < CONF_MIN) status_next = ST_RANGE;
                            else                     dist_next   = ev.distance;
                        end
                        default: status_next = ST_HWFAIL;
                    endcase
                end
            end
            default: status_next = ST_HWFAIL;
        endcase
    end

    // Output register and error count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            errs_reg  <= '0;
        end else begin
            if (ev_pop) begin
                valid_reg <= 1'b1;
                errs_reg  <= errs_next;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_pop) begin
            status_reg <= status_next;
            dist_reg   <= dist_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_dist   = dist_reg;
    assign out_errs   = errs_reg;

    a_dist_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && (status_reg != ST_VALID)) |-> (dist_reg == 16'd0))
        else $error("distance set on a non-valid result");

    a_errs_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev_pop && (ev.kind == EV_BAD)) |=> (errs_reg == $past(errs_reg) + 16'd1))
        else $error("bad-sum count did not advance");

    a_errs_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ev_pop && (ev.kind == EV_BAD)) |=> $stable(errs_reg))
        else $error("bad-sum count changed without a bad frame");

endmodule
